### rtl/swept_sphere_collision_test_macros.svh
// Assertion macros used by swept_sphere_collision_test.
`ifndef SWEPT_SPHERE_COLLISION_TEST_MACROS_SVH
`define SWEPT_SPHERE_COLLISION_TEST_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sscol_pkg.sv
package sscol_pkg;
	localparam int MAX_STEPS = 64;
	localparam int CW = 32;
	localparam int RW = CW - 1;
	localparam int KW = $clog2(MAX_STEPS + 1);
	localparam int PW = CW + KW + 2;
	localparam int NW = RW + KW + 1;
	localparam int ACC_W = 2 * PW + 2;
	localparam int LIMW = 2 * CW;
	localparam int LW = CW + 1;
	localparam int NUMW = CW + RW;
	localparam int ITW = $clog2(NUMW + 1);
	localparam int SDW = ((6 * CW + 2 * RW + 3 * CW + 7) / 8) * 8;
	localparam int MDW = 8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LIM,
		ST_LIMW,
		ST_DST,
		ST_DSTW,
		ST_LEN,
		ST_LENW,
		ST_SQRT,
		ST_PROD,
		ST_PRODW,
		ST_DIV,
		ST_BOUND,
		ST_BOUNDW,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic start;
		logic clear;
	} mac_req_t;

	function automatic logic [PW-1:0] mag_pw(logic signed [PW-1:0] v);
		return v[PW-1] ? PW'(-v) : v;
	endfunction
endpackage

### rtl/sscol_mac.sv
module sscol_mac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sscol_pkg::mac_req_t       req,
	input  logic [sscol_pkg::PW-1:0]  a,
	input  logic [sscol_pkg::PW-1:0]  b,
	output logic [sscol_pkg::ACC_W-1:0] acc,
	output logic                      busy
);
	import sscol_pkg::*;

	logic [ACC_W-1:0] a_q;
	logic [ACC_W-1:0] acc_q;
	logic [PW-1:0]    b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
		end else if (req.start) begin
			b_q <= b;
		end else if (b_q != '0) begin
			b_q <= b_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= ACC_W'(a);
			if (req.clear) begin
				acc_q <= '0;
			end
		end else if (b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
		end
	end

	assign acc = acc_q;
	assign busy = (b_q != '0);
endmodule

### rtl/swept_sphere_collision_test.sv
// Swept sphere collision test.
// One request word on s_axis carries the moving sphere (centre, motion over
// the last step, radius) and the other sphere (centre, radius), all Q16.16.
// One result word on m_axis carries hit in bit 0 and step_cap_reached in bit 1.
// The block takes one request at a time: s_axis_tready is high only while it
// is idle. All products come from one shift-and-add multiplier; the square root
// and each of the three step divisions work one result bit at a time.
// A direct hit ends after the first distance check. A miss first computes the
// motion length, its square root and the three step sizes, and then takes up
// to 64 samples along the motion.
// The result sits in an output register; a new request is taken while it
// waits, and the block only stalls at the end of the next request if the
// receiver has still not taken the previous word.
// Reset (arst_n low) returns the block to idle and drops any pending result.
module swept_sphere_collision_test (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// own_x, own_y, own_z, move_dx, move_dy, move_dz, own_radius,
	// other_x, other_y, other_z, other_radius, zero fill
	input  logic [sscol_pkg::SDW-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// hit, step_cap_reached, zero fill
	output logic [sscol_pkg::MDW-1:0]  m_axis_tdata
);
	import sscol_pkg::*;

	`include "swept_sphere_collision_test_macros.svh"

	state_t state_q, state_d;
	mac_req_t mac_req;
	logic [PW-1:0] mac_a, mac_b;
	logic [ACC_W-1:0] mac_acc;
	logic mac_busy;

	logic signed [PW-1:0] own_q [3];
	logic signed [PW-1:0] p_q [3];
	logic signed [PW-1:0] t_q [3];
	logic signed [PW-1:0] s_q [3];
	logic signed [CW-1:0] d_q [3];
	logic [RW-1:0] r1_q, r2_q;
	logic [LIMW-1:0] lim_q;
	logic [2*LW-1:0] dlen_q, rad_q;
	logic [LW-1:0] len_q;
	logic [LW+1:0] srem_q;
	logic [LW:0] drem_q;
	logic [NUMW-1:0] num_q, quo_q;
	logic [NW-1:0] n_q;
	logic [KW-1:0] k_q;
	logic [1:0] ax_q;
	logic loop_q, hit_q, cap_q;
	logic [ITW-1:0] it_q;
	logic out_valid_q, out_hit_q, out_cap_q;

	logic accept, last_ax, dist_hit, bound_out, cap_now;
	logic [CW-1:0] tr;
	logic signed [PW-1:0] diff;
	logic [PW-1:0] dmag;
	logic [CW-1:0] dabs;
	logic [LW+3:0] srem_sh;
	logic [LW+3:0] strial;
	logic sge;
	logic [LW+1:0] drem_sh;
	logic dge;
	logic [NUMW-1:0] quo_n;
	logic signed [PW-1:0] step_v;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign last_ax = (ax_q == 2'd2);
	assign tr = CW'(r1_q) + CW'(r2_q);
	assign diff = (loop_q ? p_q[ax_q] : own_q[ax_q]) - t_q[ax_q];
	assign dmag = mag_pw(diff);
	assign dabs = d_q[ax_q][CW-1] ? CW'(-d_q[ax_q]) : CW'(d_q[ax_q]);
	assign dist_hit = (mac_acc < ACC_W'(lim_q));
	assign bound_out = (mac_acc > ACC_W'(dlen_q));
	assign cap_now = (k_q >= KW'(MAX_STEPS));

	assign srem_sh = {srem_q, rad_q[2*LW-1 -: 2]};
	assign strial = (LW + 4)'({len_q, 2'b01});
	assign sge = (srem_sh >= strial);
	assign drem_sh = {drem_q, num_q[NUMW-1]};
	assign dge = (drem_sh >= (LW + 2)'(len_q));
	assign quo_n = {quo_q[NUMW-2:0], dge};
	always_comb begin
		if (len_q == '0) begin
			step_v = '0;
		end else if (d_q[ax_q][CW-1]) begin
			step_v = -PW'(quo_n[RW-1:0]);
		end else begin
			step_v = PW'(quo_n[RW-1:0]);
		end
	end

	always_comb begin
		state_d = state_q;
		mac_req = '0;
		mac_a = dmag;
		mac_b = dmag;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LIM;
				end
			end
			ST_LIM: begin
				mac_req = '{start: 1'b1, clear: 1'b1};
				mac_a = PW'(tr);
				mac_b = PW'(tr);
				state_d = ST_LIMW;
			end
			ST_LIMW: begin
				if (!mac_busy) begin
					state_d = ST_DST;
				end
			end
			ST_DST: begin
				mac_req = '{start: 1'b1, clear: (ax_q == 2'd0)};
				state_d = ST_DSTW;
			end
			ST_DSTW: begin
				if (!mac_busy) begin
					if (!last_ax) begin
						state_d = ST_DST;
					end else if (dist_hit) begin
						state_d = ST_FIN;
					end else if (loop_q) begin
						state_d = ST_BOUND;
					end else begin
						state_d = ST_LEN;
					end
				end
			end
			ST_LEN: begin
				mac_req = '{start: 1'b1, clear: (ax_q == 2'd0)};
				mac_a = PW'(dabs);
				mac_b = PW'(dabs);
				state_d = ST_LENW;
			end
			ST_LENW: begin
				if (!mac_busy) begin
					state_d = last_ax ? ST_SQRT : ST_LEN;
				end
			end
			ST_SQRT: begin
				if (it_q == ITW'(LW - 1)) begin
					state_d = ST_PROD;
				end
			end
			ST_PROD: begin
				mac_req = '{start: 1'b1, clear: 1'b1};
				mac_a = PW'(dabs);
				mac_b = PW'(r1_q);
				state_d = ST_PRODW;
			end
			ST_PRODW: begin
				if (!mac_busy) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (it_q == ITW'(NUMW - 1)) begin
					state_d = last_ax ? ST_BOUND : ST_PROD;
				end
			end
			ST_BOUND: begin
				mac_req = '{start: 1'b1, clear: 1'b1};
				mac_a = PW'(n_q);
				mac_b = PW'(n_q);
				state_d = ST_BOUNDW;
			end
			ST_BOUNDW: begin
				if (!mac_busy) begin
					state_d = (bound_out || cap_now) ? ST_FIN : ST_DST;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					for (int i = 0; i < 3; i++) begin
						own_q[i] <= PW'($signed(s_axis_tdata[i*CW +: CW]));
						d_q[i] <= $signed(s_axis_tdata[(3+i)*CW +: CW]);
						t_q[i] <= PW'($signed(s_axis_tdata[6*CW+RW+i*CW +: CW]));
						p_q[i] <= PW'($signed(s_axis_tdata[i*CW +: CW]))
							- PW'($signed(s_axis_tdata[(3+i)*CW +: CW]));
					end
					r1_q <= s_axis_tdata[6*CW +: RW];
					r2_q <= s_axis_tdata[9*CW+RW +: RW];
					n_q <= NW'(s_axis_tdata[6*CW +: RW]);
					ax_q <= 2'd0;
					k_q <= '0;
					loop_q <= 1'b0;
					hit_q <= 1'b0;
					cap_q <= 1'b0;
				end
			end
			ST_LIMW: begin
				lim_q <= mac_acc[LIMW-1:0];
			end
			ST_DSTW: begin
				if (!mac_busy) begin
					if (!last_ax) begin
						ax_q <= ax_q + 2'd1;
					end else begin
						ax_q <= 2'd0;
						if (dist_hit) begin
							hit_q <= 1'b1;
						end else if (loop_q) begin
							for (int i = 0; i < 3; i++) begin
								p_q[i] <= p_q[i] + s_q[i];
							end
							k_q <= k_q + KW'(1);
							n_q <= n_q + NW'(r1_q);
						end
					end
				end
			end
			ST_LENW: begin
				if (!mac_busy) begin
					ax_q <= last_ax ? 2'd0 : ax_q + 2'd1;
					dlen_q <= mac_acc[2*LW-1:0];
					rad_q <= mac_acc[2*LW-1:0];
					srem_q <= '0;
					len_q <= '0;
					it_q <= '0;
				end
			end
			ST_SQRT: begin
				srem_q <= sge ? (LW + 2)'(srem_sh - strial) : srem_sh[LW+1:0];
				len_q <= {len_q[LW-2:0], sge};
				rad_q <= rad_q << 2;
				it_q <= it_q + ITW'(1);
			end
			ST_PRODW: begin
				num_q <= mac_acc[NUMW-1:0];
				drem_q <= '0;
				quo_q <= '0;
				it_q <= '0;
			end
			ST_DIV: begin
				drem_q <= dge ? (LW + 1)'(drem_sh - (LW + 2)'(len_q)) : drem_sh[LW:0];
				quo_q <= quo_n;
				num_q <= num_q << 1;
				it_q <= it_q + ITW'(1);
				if (it_q == ITW'(NUMW - 1)) begin
					s_q[ax_q] <= step_v;
					ax_q <= last_ax ? 2'd0 : ax_q + 2'd1;
					loop_q <= last_ax;
				end
			end
			ST_BOUNDW: begin
				if (!mac_busy && !bound_out && cap_now) begin
					cap_q <= 1'b1;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || m_axis_tready) begin
					out_hit_q <= hit_q;
					out_cap_q <= cap_q;
				end
			end
			default: begin
			end
		endcase
	end

	sscol_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (mac_acc),
		.busy   (mac_busy)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(MDW - 2){1'b0}}, out_cap_q, out_hit_q};

	`SSC_ASSERT_NOW(a_hit_cap_excl, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]),
		"hit and step cap reported together")
	`SSC_ASSERT_NOW(a_mac_idle_start, mac_req.start, !mac_busy,
		"multiplier started while busy")
	`SSC_ASSERT_NOW(a_k_bound, state_q != ST_IDLE, k_q <= KW'(MAX_STEPS),
		"sample count beyond the step limit")
	`SSC_ASSERT_NEXT(a_fin_loaded, state_q == ST_FIN && state_d == ST_IDLE,
		m_axis_tvalid, "finished result not presented")
endmodule
